// ----- src/cir_pkg.sv -----
package cir_pkg;

  localparam int unsigned IdW   = 6;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned EvW   = 2;

  localparam logic [CfgW-1:0] TimeoutReset = 16'd15;

  localparam logic [ModeW-1:0] MODE_ACTIVITY = 2'd0;
  localparam logic [ModeW-1:0] MODE_HANGUP   = 2'd1;
  localparam logic [ModeW-1:0] MODE_TICK     = 2'd2;

  localparam logic [EvW-1:0] EV_NONE    = 2'd0;
  localparam logic [EvW-1:0] EV_TIMEOUT = 2'd1;
  localparam logic [EvW-1:0] EV_HANGUP  = 2'd2;

endpackage

// ----- src/connection_idle_reaper_core.sv -----
// activity, hangup, ignored items: ACT, HANG or NOP registers the result and busy drops with it
// tick: advance time, pop expired ring entries (HEAD, DLRD, CMP), then read out each close
// one shared 32-bit adder serves deadline set, time advance and deadline compare
// ring, deadline and close list sit in single-port-read rams with registered reads
// reset is immediate: deadline and alive tables clear through flip-flop valid bits
// results cannot be stalled by the receiver, each strobe lasts exactly one cycle
module connection_idle_reaper_core #(
  parameter int unsigned NUM_CONNECTIONS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [cir_pkg::ModeW-1:0] mode_i,
  input  logic [cir_pkg::IdW-1:0]   conn_id_i,
  input  logic                      keep_open_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cir_pkg::CfgW-1:0]  keep_alive_timeout_i,
  output logic                      res_strobe_o,
  output logic [cir_pkg::EvW-1:0]   event_res_o,
  output logic [cir_pkg::IdW-1:0]   closed_conn_o,
  output logic                      last_o,
  output logic                      queue_busy_o,
  output logic                      overflow_o
);

  import cir_pkg::*;

  localparam int unsigned AW = $clog2(NUM_CONNECTIONS);
  localparam int unsigned CW = $clog2(NUM_CONNECTIONS + 1);
  localparam logic [CW-1:0] OccFull = CW'(NUM_CONNECTIONS);
  localparam logic [AW-1:0] PtrLast = AW'(NUM_CONNECTIONS - 1);
  localparam logic [IdW:0]  IdLimit = (IdW+1)'(NUM_CONNECTIONS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACT, ST_HANG, ST_NOP, ST_TICK, ST_HEAD, ST_DLRD, ST_CMP, ST_FIN, ST_EMRD,
    ST_EMOUT
  } state_e;

  state_e               state_q;
  logic [IdW-1:0]       id_q;
  logic                 keep_q;
  logic [CfgW-1:0]      timeout_q;
  logic [TimeW-1:0]     now_q;
  logic [AW-1:0]        head_q, tail_q;
  logic [CW-1:0]        occ_q;
  logic [CW-1:0]        n_q, k_q;
  logic [NUM_CONNECTIONS-1:0] alive_q, dlv_q;
  logic [IdW-1:0]       hid_q;
  logic                 dl_vld_q;

  logic                 res_strobe_q, last_q, qb_q, ovf_q;
  logic [EvW-1:0]       ev_q;
  logic [IdW-1:0]       cc_q;

  logic [TimeW-1:0]     add_a, add_b, add_sum, dl;
  logic                 add_ci;
  logic [IdW-1:0]       ring_rdata, closed_rdata;
  logic [TimeW-1:0]     dl_rdata;
  logic                 accept, in_range, future, pop_close;
  logic [AW-1:0]        id_idx, hid_idx;

  assign accept   = start && !busy;
  assign in_range = {1'b0, conn_id_i} < IdLimit;
  assign busy     = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign id_idx   = id_q[AW-1:0];
  assign hid_idx  = hid_q[AW-1:0];

  // shared adder
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (state_q)
      ST_ACT: begin
        add_a = now_q;
        add_b = keep_q ? {{(TimeW-CfgW){1'b0}}, timeout_q} : '0;
      end
      ST_TICK: begin
        add_a  = now_q;
        add_ci = 1'b1;
      end
      ST_CMP: begin
        add_a  = dl;
        add_b  = ~now_q;
        add_ci = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_sum   = add_a + add_b + {{(TimeW-1){1'b0}}, add_ci};
  assign dl        = dl_vld_q ? dl_rdata : '0;
  assign future    = (add_sum != '0) && !add_sum[TimeW-1];
  assign pop_close = (state_q == ST_CMP) && !future && alive_q[hid_idx];

  cir_ram #(.WIDTH(IdW), .DEPTH(NUM_CONNECTIONS)) u_ring (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_ACT) && !alive_q[id_idx] && (occ_q != OccFull)),
    .waddr_i (tail_q),
    .wdata_i (id_q),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  cir_ram #(.WIDTH(TimeW), .DEPTH(NUM_CONNECTIONS)) u_deadline (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_ACT),
    .waddr_i (id_idx),
    .wdata_i (add_sum),
    .raddr_i (ring_rdata[AW-1:0]),
    .rdata_o (dl_rdata)
  );

  cir_ram #(.WIDTH(IdW), .DEPTH(NUM_CONNECTIONS)) u_closed (
    .clk_i   (clk_i),
    .we_i    (pop_close),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (hid_q),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (closed_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      id_q         <= '0;
      keep_q       <= 1'b0;
      timeout_q    <= TimeoutReset;
      now_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      occ_q        <= '0;
      n_q          <= '0;
      k_q          <= '0;
      alive_q      <= '0;
      dlv_q        <= '0;
      hid_q        <= '0;
      dl_vld_q     <= 1'b0;
      res_strobe_q <= 1'b0;
      ev_q         <= EV_NONE;
      cc_q         <= '0;
      last_q       <= 1'b0;
      qb_q         <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      res_strobe_q <= 1'b0;
      if (cfg_valid_i) begin
        timeout_q <= keep_alive_timeout_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            id_q   <= conn_id_i;
            keep_q <= keep_open_i;
            if (mode_i == MODE_ACTIVITY && in_range) begin
              state_q <= ST_ACT;
            end else if (mode_i == MODE_HANGUP && in_range) begin
              state_q <= ST_HANG;
            end else if (mode_i == MODE_TICK) begin
              state_q <= ST_TICK;
            end else begin
              state_q <= ST_NOP;
            end
          end
        end
        ST_ACT: begin
          dlv_q[id_idx] <= 1'b1;
          res_strobe_q  <= 1'b1;
          ev_q          <= EV_NONE;
          cc_q          <= '0;
          last_q        <= 1'b1;
          ovf_q         <= 1'b0;
          qb_q          <= occ_q != '0;
          if (!alive_q[id_idx]) begin
            if (occ_q == OccFull) begin
              ovf_q <= 1'b1;
            end else begin
              tail_q          <= (tail_q == PtrLast) ? '0 : tail_q + AW'(1);
              occ_q           <= occ_q + CW'(1);
              alive_q[id_idx] <= 1'b1;
              qb_q            <= 1'b1;
            end
          end
          state_q <= ST_IDLE;
        end
        ST_HANG: begin
          alive_q[id_idx] <= 1'b0;
          res_strobe_q    <= 1'b1;
          ev_q            <= EV_HANGUP;
          cc_q            <= id_q;
          last_q          <= 1'b1;
          qb_q            <= occ_q != '0;
          ovf_q           <= 1'b0;
          state_q         <= ST_IDLE;
        end
        ST_NOP: begin
          res_strobe_q <= 1'b1;
          ev_q         <= EV_NONE;
          cc_q         <= '0;
          last_q       <= 1'b1;
          qb_q         <= occ_q != '0;
          ovf_q        <= 1'b0;
          state_q      <= ST_IDLE;
        end
        ST_TICK: begin
          now_q   <= add_sum;
          n_q     <= '0;
          state_q <= ST_HEAD;
        end
        ST_HEAD: begin
          state_q <= (occ_q == '0) ? ST_FIN : ST_DLRD;
        end
        ST_DLRD: begin
          hid_q    <= ring_rdata;
          dl_vld_q <= dlv_q[ring_rdata[AW-1:0]];
          state_q  <= ST_CMP;
        end
        ST_CMP: begin
          if (future) begin
            state_q <= ST_FIN;
          end else begin
            head_q <= (head_q == PtrLast) ? '0 : head_q + AW'(1);
            occ_q  <= occ_q - CW'(1);
            if (alive_q[hid_idx]) begin
              alive_q[hid_idx] <= 1'b0;
              n_q              <= n_q + CW'(1);
            end
            state_q <= ST_HEAD;
          end
        end
        ST_FIN: begin
          k_q <= '0;
          if (n_q == '0) begin
            res_strobe_q <= 1'b1;
            ev_q         <= EV_NONE;
            cc_q         <= '0;
            last_q       <= 1'b1;
            qb_q         <= occ_q != '0;
            ovf_q        <= 1'b0;
            state_q      <= ST_IDLE;
          end else begin
            state_q <= ST_EMRD;
          end
        end
        ST_EMRD: begin
          state_q <= ST_EMOUT;
        end
        ST_EMOUT: begin
          res_strobe_q <= 1'b1;
          ev_q         <= EV_TIMEOUT;
          cc_q         <= closed_rdata;
          last_q       <= (k_q + CW'(1)) == n_q;
          qb_q         <= occ_q != '0;
          ovf_q        <= 1'b0;
          k_q          <= k_q + CW'(1);
          state_q      <= ((k_q + CW'(1)) == n_q) ? ST_IDLE : ST_EMRD;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_strobe_o  = res_strobe_q;
  assign event_res_o   = ev_q;
  assign closed_conn_o = cc_q;
  assign last_o        = last_q;
  assign queue_busy_o  = qb_q;
  assign overflow_o    = ovf_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccFull)
    else $error("ring occupancy above capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (occ_q != '0))
    else $error("pop from empty ring");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item left no work");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_q && ev_q == EV_NONE) |-> last_q)
    else $error("empty result not final");

  a_close_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= OccFull)
    else $error("close list overrun");

endmodule

// ----- src/cir_ram.sv -----
module cir_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
